FILE: hw/rtl/ekfc_pkg.sv
// EAPOL-Key frame classifier: shared types, codes and frame offsets.
// No dependencies; used by every module of the block.
package ekfc_pkg;

   // Ethernet and EAPOL-Key layout
   localparam int unsigned ETH_HDR_BYTES    = 14;
   localparam int unsigned KEY_FIXED_BYTES  = 99;
   localparam int unsigned KEY_DATA_LEN_POS = 97;
   localparam int unsigned MIN_FRAME_BYTES  = ETH_HDR_BYTES + KEY_FIXED_BYTES;

   localparam logic [15:0] ETHERTYPE_EAPOL = 16'h888e;
   localparam logic [7:0]  EAPOL_TYPE_KEY  = 8'd3;
   localparam logic [7:0]  DESCRIPTOR_RSN  = 8'd2;
   localparam logic [16:0] EAPOL_HDR_BYTES = 17'd4;

   // Key information bits
   localparam logic [15:0] VERSION_MASK = 16'h0007;
   localparam logic [15:0] VERSION_SHA1 = 16'h0002;
   localparam logic [15:0] BIT_PAIRWISE = 16'h0008;
   localparam logic [15:0] BIT_INSTALL  = 16'h0040;
   localparam logic [15:0] BIT_ACK      = 16'h0080;
   localparam logic [15:0] BIT_MIC      = 16'h0100;
   localparam logic [15:0] BIT_ERROR    = 16'h0400;
   localparam logic [15:0] BIT_REQUEST  = 16'h0800;
   localparam logic [15:0] SEL_MASK     = BIT_PAIRWISE | BIT_INSTALL | BIT_ACK | BIT_MIC;
   localparam logic [15:0] SEL_MSG1     = BIT_PAIRWISE | BIT_ACK;
   localparam logic [15:0] SEL_MSG3     = BIT_PAIRWISE | BIT_INSTALL | BIT_ACK | BIT_MIC;

   // Byte positions of captured fields
   localparam logic [15:0] POS_ETYPE_HI  = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO  = 16'd13;
   localparam logic [15:0] POS_PTYPE     = 16'd15;
   localparam logic [15:0] POS_BODY_HI   = 16'd16;
   localparam logic [15:0] POS_BODY_LO   = 16'd17;
   localparam logic [15:0] POS_DESC      = 16'd18;
   localparam logic [15:0] POS_KINFO_HI  = 16'd19;
   localparam logic [15:0] POS_KINFO_LO  = 16'd20;
   localparam logic [15:0] POS_KLEN_HI   = 16'd21;
   localparam logic [15:0] POS_KLEN_LO   = 16'd22;
   localparam logic [15:0] POS_KDLEN_HI  = 16'(ETH_HDR_BYTES + KEY_DATA_LEN_POS);
   localparam logic [15:0] POS_KDLEN_LO  = 16'(ETH_HDR_BYTES + KEY_DATA_LEN_POS + 1);

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_INVALID     = 2'd1,
      STATUS_PROTOCOL    = 2'd2,
      STATUS_UNSUPPORTED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_MSG1    = 2'd1,
      KIND_MSG3    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      status_type  status;
      kind_type    message_kind;
      logic [15:0] key_information;
      logic [15:0] key_len_field;
      logic [16:0] eapol_total_length;
      logic [15:0] key_data_len_field;
      logic [15:0] frame_byte_count;
   } rsp_type;

   // Fields captured over one frame
   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] ether_type;
      logic [7:0]  packet_type;
      logic [15:0] body_length;
      logic [7:0]  descriptor;
      logic [15:0] info_word;
      logic [15:0] size_word;
      logic [15:0] data_length;
   } frame_fields_type;

endpackage

FILE: hw/rtl/eapol_key_frame_classifier_core.sv
// EAPOL-Key frame classifier top level: handshakes, capture, checks, result register.
// Depends on ekfc_pkg, ekfc_capture and ekfc_classify.
//
//   channel | direction | transfer                     | handshake
//   req_    | in        | one frame byte + last flag   | req_valid / req_stall
//   rsp_    | out       | one result per frame         | rsp_valid / rsp_stall
//
// One byte per cycle is taken while req_stall is low; the result passes the snapshot
// register, then the result register behind the check logic.
// Reset clears the byte counter, captured fields and both valid flags.
// A stalled result holds; one further frame end can wait in the snapshot slot,
// after which req_stall rises until the result is taken.
module eapol_key_frame_classifier_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ekfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ekfc_pkg::rsp_type rsp_data
);

   ekfc_pkg::frame_fields_type snap_fields;
   ekfc_pkg::rsp_type          result;
   ekfc_pkg::rsp_type          rsp_data_ff;
   logic                       snap_valid;
   logic                       snap_take;
   logic                       byte_take;
   logic                       out_free;
   logic                       rsp_valid_ff, rsp_valid_in;

   // flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign snap_take = snap_valid && out_free;
   assign req_stall = snap_valid && !out_free;
   assign byte_take = req_valid && !req_stall;

   ekfc_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .byte_take   (byte_take),
      .req_data    (req_data),
      .snap_take   (snap_take),
      .snap_valid  (snap_valid),
      .snap_fields (snap_fields)
   );

   ekfc_classify u_classify (
      .fields (snap_fields),
      .result (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/ekfc_capture.sv
// EAPOL-Key frame classifier: byte counter, field capture and frame snapshot register.
// Depends on ekfc_pkg.
module ekfc_capture (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_take,
   input  ekfc_pkg::req_type           req_data,
   input  logic                        snap_take,
   output logic                        snap_valid,
   output ekfc_pkg::frame_fields_type  snap_fields
);

   ekfc_pkg::frame_fields_type fields_ff, fields_in, cur;
   ekfc_pkg::frame_fields_type snap_fields_ff;
   logic                       snap_valid_ff, snap_valid_in;
   logic                       frame_done;

   assign frame_done = byte_take && req_data.frame_end;

   // capture at the current position, then count with saturation
   always_comb begin
      cur = fields_ff;
      if (fields_ff.byte_count != ekfc_pkg::COUNT_MAX) begin
         cur.byte_count = fields_ff.byte_count + 16'd1;
      end
      unique case (fields_ff.byte_count)
         ekfc_pkg::POS_ETYPE_HI: cur.ether_type[15:8]  = req_data.data_byte;
         ekfc_pkg::POS_ETYPE_LO: cur.ether_type[7:0]   = req_data.data_byte;
         ekfc_pkg::POS_PTYPE:    cur.packet_type       = req_data.data_byte;
         ekfc_pkg::POS_BODY_HI:  cur.body_length[15:8] = req_data.data_byte;
         ekfc_pkg::POS_BODY_LO:  cur.body_length[7:0]  = req_data.data_byte;
         ekfc_pkg::POS_DESC:     cur.descriptor        = req_data.data_byte;
         ekfc_pkg::POS_KINFO_HI: cur.info_word[15:8]   = req_data.data_byte;
         ekfc_pkg::POS_KINFO_LO: cur.info_word[7:0]    = req_data.data_byte;
         ekfc_pkg::POS_KLEN_HI:  cur.size_word[15:8]   = req_data.data_byte;
         ekfc_pkg::POS_KLEN_LO:  cur.size_word[7:0]    = req_data.data_byte;
         ekfc_pkg::POS_KDLEN_HI: cur.data_length[15:8] = req_data.data_byte;
         ekfc_pkg::POS_KDLEN_LO: cur.data_length[7:0]  = req_data.data_byte;
         default: ;
      endcase
   end

   // state clears after the last byte of a frame
   always_comb begin
      fields_in = fields_ff;
      if (byte_take) begin
         fields_in = req_data.frame_end ? '0 : cur;
      end
   end

   // snapshot slot: filled on the last byte, emptied when taken downstream
   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (snap_take) begin
         snap_valid_in = 1'b0;
      end
      if (frame_done) begin
         snap_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fields_ff     <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         fields_ff     <= fields_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         snap_fields_ff <= cur;
      end
   end

   assign snap_valid  = snap_valid_ff;
   assign snap_fields = snap_fields_ff;

endmodule

FILE: hw/rtl/ekfc_classify.sv
// EAPOL-Key frame classifier: ordered frame checks and message classification.
// Depends on ekfc_pkg.
module ekfc_classify (
   input  ekfc_pkg::frame_fields_type fields,
   output ekfc_pkg::rsp_type          result
);

   logic [16:0] total_len;
   logic [16:0] avail_len;
   logic [16:0] key_room;
   logic [15:0] sel;
   logic        is_short;
   logic        bad_frame;
   logic        bad_key;
   logic        big_data;

   assign total_len = {1'b0, fields.body_length} + ekfc_pkg::EAPOL_HDR_BYTES;
   assign avail_len = {1'b0, fields.byte_count} - 17'(ekfc_pkg::ETH_HDR_BYTES);
   assign key_room  = total_len - 17'(ekfc_pkg::KEY_FIXED_BYTES);
   assign sel       = fields.info_word & ekfc_pkg::SEL_MASK;

   assign is_short  = (fields.byte_count < 16'(ekfc_pkg::MIN_FRAME_BYTES))
                   || (fields.ether_type != ekfc_pkg::ETHERTYPE_EAPOL);
   assign bad_frame = (total_len < 17'(ekfc_pkg::KEY_FIXED_BYTES))
                   || (total_len > avail_len)
                   || (fields.packet_type != ekfc_pkg::EAPOL_TYPE_KEY)
                   || (fields.descriptor != ekfc_pkg::DESCRIPTOR_RSN);
   assign bad_key   = ((fields.info_word & ekfc_pkg::VERSION_MASK) != ekfc_pkg::VERSION_SHA1)
                   || ((fields.info_word & (ekfc_pkg::BIT_ERROR | ekfc_pkg::BIT_REQUEST))
                       != 16'd0);
   assign big_data  = {1'b0, fields.data_length} > key_room;

   // first failing check wins
   always_comb begin
      result.message_kind       = ekfc_pkg::KIND_UNKNOWN;
      result.key_information    = fields.info_word;
      result.key_len_field      = fields.size_word;
      result.eapol_total_length = total_len;
      result.key_data_len_field = fields.data_length;
      result.frame_byte_count   = fields.byte_count;
      priority if (is_short) begin
         result.status = ekfc_pkg::STATUS_INVALID;
      end else if (bad_frame) begin
         result.status = ekfc_pkg::STATUS_PROTOCOL;
      end else if (bad_key) begin
         result.status = ekfc_pkg::STATUS_UNSUPPORTED;
      end else if (big_data) begin
         result.status = ekfc_pkg::STATUS_PROTOCOL;
      end else if (sel == ekfc_pkg::SEL_MSG1) begin
         result.status       = ekfc_pkg::STATUS_OK;
         result.message_kind = ekfc_pkg::KIND_MSG1;
      end else if (sel == ekfc_pkg::SEL_MSG3) begin
         result.status       = ekfc_pkg::STATUS_OK;
         result.message_kind = ekfc_pkg::KIND_MSG3;
      end else begin
         result.status = ekfc_pkg::STATUS_PROTOCOL;
      end
   end

endmodule

FILE: hw/rtl/ekfc_checker.sv
// EAPOL-Key frame classifier: port-level checker and its bind to the top level.
// Depends on ekfc_pkg and eapol_key_frame_classifier_core.
module ekfc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ekfc_pkg::rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a failed frame never carries a message kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ekfc_pkg::STATUS_OK)
      |-> rsp_data.message_kind == ekfc_pkg::KIND_UNKNOWN)
      else $error("message kind on failed frame");

   // a good frame is message 1 or message 3
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ekfc_pkg::STATUS_OK)
      |-> (rsp_data.message_kind == ekfc_pkg::KIND_MSG1)
       || (rsp_data.message_kind == ekfc_pkg::KIND_MSG3))
      else $error("good frame without message kind");

   // frames past the first check are long enough
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ekfc_pkg::STATUS_INVALID)
      |-> rsp_data.frame_byte_count >= 16'(ekfc_pkg::MIN_FRAME_BYTES))
      else $error("short frame passed length check");

   // the input only stalls behind a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with result path free");

endmodule

bind eapol_key_frame_classifier_core ekfc_checker u_ekfc_checker (.*);

FILE: dv/tb_eapol_key_frame_classifier_core.sv
`timescale 1ns / 100ps
// Testbench for eapol_key_frame_classifier_core: directed and random frames,
// each verdict checked against a byte-level predictor. Depends on ekfc_pkg and eapol_key_frame_classifier_core.
module tb_eapol_key_frame_classifier_core;
   import ekfc_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predictor state and pending verdicts
   frame_fields_type captured_fields = '0;
   rsp_type          pending_verdicts[$];
   logic [7:0]       frame_buf[$];

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int          hold_off_left = 0;
   int unsigned mismatch_count = 0;

   eapol_key_frame_classifier_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4ns clock = ~clock;

   // Checks run on the saturated count and the captured words, in fixed order
   function automatic rsp_type verdict_for(frame_fields_type f);
      rsp_type     r;
      int unsigned len;
      int unsigned plen;
      logic [15:0] sel;
      len  = f.byte_count;
      plen = int'(f.body_length) + 4;
      sel  = f.info_word & SEL_MASK;
      r.key_information    = f.info_word;
      r.key_len_field      = f.size_word;
      r.eapol_total_length = 17'(plen);
      r.key_data_len_field = f.data_length;
      r.frame_byte_count   = f.byte_count;
      r.message_kind       = KIND_UNKNOWN;
      if (len < MIN_FRAME_BYTES || f.ether_type != ETHERTYPE_EAPOL) begin
         r.status = STATUS_INVALID;
      end else if (plen < KEY_FIXED_BYTES || plen > len - ETH_HDR_BYTES ||
                   f.packet_type != EAPOL_TYPE_KEY || f.descriptor != DESCRIPTOR_RSN) begin
         r.status = STATUS_PROTOCOL;
      end else if ((f.info_word & VERSION_MASK) != VERSION_SHA1 ||
                   (f.info_word & (BIT_ERROR | BIT_REQUEST)) != 16'h0000) begin
         r.status = STATUS_UNSUPPORTED;
      end else if (int'(f.data_length) > plen - KEY_FIXED_BYTES) begin
         r.status = STATUS_PROTOCOL;
      end else if (sel == SEL_MSG1) begin
         r.status       = STATUS_OK;
         r.message_kind = KIND_MSG1;
      end else if (sel == SEL_MSG3) begin
         r.status       = STATUS_OK;
         r.message_kind = KIND_MSG3;
      end else begin
         r.status = STATUS_PROTOCOL;
      end
      return r;
   endfunction

   // Capture one accepted byte; the last byte of a frame yields a verdict
   function automatic void track_frame_byte(req_type item);
      case (captured_fields.byte_count)
         POS_ETYPE_HI: captured_fields.ether_type[15:8]  = item.data_byte;
         POS_ETYPE_LO: captured_fields.ether_type[7:0]   = item.data_byte;
         POS_PTYPE:    captured_fields.packet_type       = item.data_byte;
         POS_BODY_HI:  captured_fields.body_length[15:8] = item.data_byte;
         POS_BODY_LO:  captured_fields.body_length[7:0]  = item.data_byte;
         POS_DESC:     captured_fields.descriptor        = item.data_byte;
         POS_KINFO_HI: captured_fields.info_word[15:8]   = item.data_byte;
         POS_KINFO_LO: captured_fields.info_word[7:0]    = item.data_byte;
         POS_KLEN_HI:  captured_fields.size_word[15:8]   = item.data_byte;
         POS_KLEN_LO:  captured_fields.size_word[7:0]    = item.data_byte;
         POS_KDLEN_HI: captured_fields.data_length[15:8] = item.data_byte;
         POS_KDLEN_LO: captured_fields.data_length[7:0]  = item.data_byte;
         default: ;
      endcase
      if (captured_fields.byte_count != COUNT_MAX)
         captured_fields.byte_count = captured_fields.byte_count + 16'd1;
      if (item.frame_end) begin
         pending_verdicts.push_back(verdict_for(captured_fields));
         captured_fields = '0;
      end
   endfunction

   // Frame assembly: random filler with the header fields laid over it
   function automatic void place_byte(int unsigned pos, logic [7:0] value);
      if (pos < frame_buf.size())
         frame_buf[pos] = value;
   endfunction

   function automatic void compose_frame(int unsigned len, logic [15:0] etype,
                                         logic [7:0] ptype, logic [15:0] body,
                                         logic [7:0] desc, logic [15:0] kinfo,
                                         logic [15:0] klen, logic [15:0] kdlen);
      frame_buf.delete();
      repeat (len) frame_buf.push_back(8'($urandom));
      place_byte(POS_ETYPE_HI, etype[15:8]);
      place_byte(POS_ETYPE_LO, etype[7:0]);
      place_byte(POS_PTYPE, ptype);
      place_byte(POS_BODY_HI, body[15:8]);
      place_byte(POS_BODY_LO, body[7:0]);
      place_byte(POS_DESC, desc);
      place_byte(POS_KINFO_HI, kinfo[15:8]);
      place_byte(POS_KINFO_LO, kinfo[7:0]);
      place_byte(POS_KLEN_HI, klen[15:8]);
      place_byte(POS_KLEN_LO, klen[7:0]);
      place_byte(POS_KDLEN_HI, kdlen[15:8]);
      place_byte(POS_KDLEN_LO, kdlen[7:0]);
   endfunction

   function automatic logic [15:0] rsn_info(logic [15:0] bits);
      return VERSION_SHA1 | bits;
   endfunction

   // One byte transfer, with random idle cycles in front of it
   task automatic push_frame_byte(req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_frame_byte(item);
   endtask

   task automatic send_frame();
      req_type item;
      foreach (frame_buf[i]) begin
         item.data_byte = frame_buf[i];
         item.frame_end = (i == frame_buf.size() - 1);
         push_frame_byte(item);
      end
   endtask

   task automatic send_key_frame(int unsigned len, logic [15:0] etype, logic [7:0] ptype,
                                 logic [15:0] body, logic [7:0] desc,
                                 logic [15:0] kinfo, logic [15:0] kdlen);
      compose_frame(len, etype, ptype, body, desc, kinfo, 16'($urandom), kdlen);
      send_frame();
   endtask

   // Receiver: random stalls, or a long hold-off while the counter runs down
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // Result checker: each transfer against the oldest pending verdict
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with no frame pending: %h", $time, rsp_data);
         end else begin
            want = pending_verdicts.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("message_kind", want.message_kind, rsp_data.message_kind);
            check_field("key_information", want.key_information, rsp_data.key_information);
            check_field("key_len_field", want.key_len_field, rsp_data.key_len_field);
            check_field("eapol_total_length", want.eapol_total_length,
                        rsp_data.eapol_total_length);
            check_field("key_data_len_field", want.key_data_len_field,
                        rsp_data.key_data_len_field);
            check_field("frame_byte_count", want.frame_byte_count,
                        rsp_data.frame_byte_count);
         end
      end
   end

   // Good frames of both handshake kinds, and key info matching neither
   task automatic test_message_kinds();
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(135, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd117, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG3) | 16'h1200, 16'd22);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(BIT_PAIRWISE | BIT_MIC), 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(BIT_ACK | BIT_MIC), 16'd4);
   endtask

   // Frame length, body length and key data length at and beyond their limits
   task automatic test_length_limits();
      send_key_frame(1, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd95, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(112, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd94, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(113, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd95, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(113, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd94, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd104, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'hFFFF, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG3), 16'd9);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG3), 16'd8);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'hFFFF);
   endtask

   // Wrong header fields, bad version, error and request bits, flat byte patterns
   task automatic test_field_checks();
      send_key_frame(121, 16'h888f, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(121, 16'h0800, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, 8'd1, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, 8'hFF, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, 8'hFE,
                     rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     16'h0001 | SEL_MSG1, 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     VERSION_MASK | SEL_MSG3, 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG3) | BIT_ERROR, 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1) | BIT_REQUEST, 16'd0);
      for (int fill = 0; fill < 2; fill++) begin
         compose_frame(130, 16'h0, 8'h0, 16'h0, 8'h0, 16'h0, 16'h0, 16'h0);
         foreach (frame_buf[i]) frame_buf[i] = (fill == 1) ? 8'hFF : 8'h00;
         send_frame();
      end
   endtask

   // A frame past 65535 bytes: the count saturates, then clears for the next frame
   task automatic test_count_saturation();
      send_key_frame(65540, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd65517, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG3), 16'($urandom_range(65422)));
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG1), 16'd8);
   endtask

   // Long receiver hold-off while tiny frames keep coming, so the input stalls
   task automatic test_back_pressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_left <= 400;
      repeat (12)
         send_key_frame(1 + $urandom_range(3), ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd95,
                        DESCRIPTOR_RSN, rsn_info(SEL_MSG1), 16'd0);
      send_key_frame(121, ETHERTYPE_EAPOL, EAPOL_TYPE_KEY, 16'd103, DESCRIPTOR_RSN,
                     rsn_info(SEL_MSG3), 16'd3);
   endtask

   // Mostly well-formed key frames, some with one field broken, plus noise frames
   task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
      int unsigned frames;
      int unsigned bytes_sent;
      int unsigned len;
      int unsigned room;
      logic [15:0] etype;
      logic [15:0] body;
      logic [15:0] kinfo;
      logic [15:0] kdlen;
      logic [7:0]  ptype;
      logic [7:0]  desc;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      frames     = 0;
      bytes_sent = 0;
      while (frames < 2 || bytes_sent < 375) begin
         if ($urandom_range(99) < 15) begin
            len = $urandom_range(1, 130);
            compose_frame(len, 16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            len   = 113 + (($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(24));
            etype = ETHERTYPE_EAPOL;
            ptype = EAPOL_TYPE_KEY;
            desc  = DESCRIPTOR_RSN;
            body  = 16'(($urandom_range(1) == 1) ? len - 18 : $urandom_range(len - 18, 95));
            room  = int'(body) + 4 - KEY_FIXED_BYTES;
            kdlen = 16'($urandom_range(room));
            kinfo = rsn_info(($urandom_range(1) == 1) ? SEL_MSG1 : SEL_MSG3) |
                    (16'($urandom) & 16'hF230);
            if ($urandom_range(99) < 35) begin
               case ($urandom_range(11))
                  0:  etype = 16'($urandom);
                  1:  ptype = 8'($urandom);
                  2:  desc = 8'($urandom);
                  3:  body = 16'($urandom);
                  4:  body = 16'(len - 17);
                  5:  body = 16'(KEY_FIXED_BYTES - 5);
                  6:  kinfo[2:0] = 3'($urandom);
                  7:  kinfo = kinfo | BIT_ERROR;
                  8:  kinfo = kinfo | BIT_REQUEST;
                  9:  kdlen = 16'(room + 1 + $urandom_range(3));
                  10: kinfo = (kinfo & ~SEL_MASK) | (16'($urandom) & SEL_MASK);
                  default: len = $urandom_range(100, 112);
               endcase
            end
            compose_frame(len, etype, ptype, body, desc, kinfo, 16'($urandom), kdlen);
         end
         send_frame();
         frames++;
         bytes_sent += len;
      end
   endtask

   // Test sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_message_kinds();
      test_length_limits();
      test_field_checks();
      test_count_saturation();
      test_back_pressure();
      test_random_traffic(0, 0);
      test_random_traffic(56, 0);
      test_random_traffic(0, 56);
      test_random_traffic(10, 10);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_eapol_key_frame_classifier_core: PASS");
      else
         $display("tb_eapol_key_frame_classifier_core: FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #10ms;
      $display("tb_eapol_key_frame_classifier_core: FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/ekfc_pkg.sv
hw/rtl/ekfc_capture.sv
hw/rtl/ekfc_classify.sv
hw/rtl/eapol_key_frame_classifier_core.sv
hw/rtl/ekfc_checker.sv
dv/tb_eapol_key_frame_classifier_core.sv
